[design/nmea_position_fix_parser_macros.svh]
// Assertion macros shared by the NMEA position parser RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef NMEA_POSITION_FIX_PARSER_MACROS_SVH
`define NMEA_POSITION_FIX_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define NMEAPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define NMEAPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NMEAPF_ASSERT(lbl, clk, rstn, prop)
`define NMEAPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/nmeapf_pkg.sv]
// Types, character codes and per-byte parsing functions of the NMEA parser.
// Used by nmeapf_parse, nmeapf_coord and the top level; depends on nothing.
`default_nettype none
package nmeapf_pkg;

  localparam int INT_W   = 20;  // integer part, up to six digits
  localparam int ICNT_W  = 3;
  localparam int FCNT_W  = 4;
  localparam int F6_W    = 20;  // fraction scaled to 1e-6 minute
  localparam int DEG_W   = 14;
  localparam int MI_W    = 7;
  localparam int MM_W    = 27;
  localparam int Q6_W    = 24;
  localparam int MAG_W   = 37;
  localparam int COORD_W = 35;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // Sentence names, candidate j at index j, first character in the top byte.
  localparam logic [5:0][39:0] NAMES = {"GNGGA", "GPGGA", "GPRMC", "GNRMC",
                                        "GPGLL", "GNGLL"};

  typedef enum logic [1:0] {
    STAT_FIX       = 2'd0,
    STAT_REJECT    = 2'd1,
    STAT_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GLL  = 2'd1,
    KIND_RMC  = 2'd2,
    KIND_GGA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VAL_EMPTY  = 2'd0,
    VAL_ACTIVE = 2'd1,
    VAL_ZERO   = 2'd2,
    VAL_OTHER  = 2'd3
  } validity_e;

  typedef enum logic [2:0] {
    ROLE_NONE,
    ROLE_LATNUM,
    ROLE_LATHEMI,
    ROLE_LONNUM,
    ROLE_LONHEMI,
    ROLE_VALID
  } role_e;

  typedef struct packed {
    logic [INT_W-1:0]  ival;
    logic [ICNT_W-1:0] icnt;
    logic [FCNT_W-1:0] fcnt;
    logic [F6_W-1:0]   f6;
    logic              dot;
    logic              bad;
    logic              nonempty;
  } num_acc_t;

  typedef struct packed {
    logic [3:0] fidx;
    logic [7:0] ccnt;
    logic [5:0] cand;
    kind_e      kind;
    num_acc_t   lat;
    num_acc_t   lon;
    logic       lat_neg;
    logic       lon_neg;
    validity_e  vcode;
    logic       last_comma;
  } parse_t;

  typedef struct packed {
    logic [INT_W-1:0] ival;
    logic [F6_W-1:0]  f6;
    logic             neg;
  } coord_t;

  typedef struct packed {
    status_e status;
    kind_e   kind;
    coord_t  lat;
    coord_t  lon;
  } line_t;

  function automatic parse_t parse_reset();
    parse_t p;
    p      = '0;
    p.cand = 6'h3F;
    return p;
  endfunction

  function automatic role_e field_role(kind_e k, logic [3:0] f);
    role_e r;
    r = ROLE_NONE;
    case (k)
      KIND_GLL: begin
        case (f)
          4'd1: r = ROLE_LATNUM;
          4'd2: r = ROLE_LATHEMI;
          4'd3: r = ROLE_LONNUM;
          4'd4: r = ROLE_LONHEMI;
          4'd6: r = ROLE_VALID;
          default: r = ROLE_NONE;
        endcase
      end
      KIND_RMC: begin
        case (f)
          4'd2: r = ROLE_VALID;
          4'd3: r = ROLE_LATNUM;
          4'd4: r = ROLE_LATHEMI;
          4'd5: r = ROLE_LONNUM;
          4'd6: r = ROLE_LONHEMI;
          default: r = ROLE_NONE;
        endcase
      end
      KIND_GGA: begin
        case (f)
          4'd2: r = ROLE_LATNUM;
          4'd3: r = ROLE_LATHEMI;
          4'd4: r = ROLE_LONNUM;
          4'd5: r = ROLE_LONHEMI;
          4'd6: r = ROLE_VALID;
          default: r = ROLE_NONE;
        endcase
      end
      default: r = ROLE_NONE;
    endcase
    return r;
  endfunction

  // Weight of the fraction digit at position k, in 1e-6 minute.
  function automatic logic [F6_W-1:0] frac_weight(logic [FCNT_W-1:0] k);
    logic [F6_W-1:0] w;
    case (k)
      4'd0: w = F6_W'(100000);
      4'd1: w = F6_W'(10000);
      4'd2: w = F6_W'(1000);
      4'd3: w = F6_W'(100);
      4'd4: w = F6_W'(10);
      4'd5: w = F6_W'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic num_acc_t num_char(num_acc_t n, logic [7:0] c,
                                        logic [ICNT_W-1:0] ilim,
                                        logic [FCNT_W-1:0] flim);
    num_acc_t   r;
    logic [3:0] d;
    r          = n;
    d          = c[3:0];
    r.nonempty = 1'b1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (n.dot) begin
        if (n.fcnt >= flim) begin
          r.bad = 1'b1;
        end else begin
          r.f6   = n.f6 + F6_W'(d) * frac_weight(n.fcnt);
          r.fcnt = n.fcnt + FCNT_W'(1);
        end
      end else begin
        if (n.icnt >= ilim) begin
          r.bad = 1'b1;
        end else begin
          r.ival = n.ival * INT_W'(10) + INT_W'(d);
          r.icnt = n.icnt + ICNT_W'(1);
        end
      end
    end else if (c == CH_DOT && !n.dot) begin
      r.dot = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic parse_t parse_char(parse_t p, logic [7:0] c,
                                        logic [ICNT_W-1:0] ilim,
                                        logic [FCNT_W-1:0] flim);
    parse_t r;
    logic   first;
    r     = p;
    first = (p.ccnt == 8'd0);
    if (c == CH_COMMA) begin
      if (p.fidx == 4'd0) begin
        r.kind = KIND_NONE;
        if (p.ccnt == 8'd5) begin
          if (|p.cand[1:0])      r.kind = KIND_GLL;
          else if (|p.cand[3:2]) r.kind = KIND_RMC;
          else if (|p.cand[5:4]) r.kind = KIND_GGA;
        end
      end
      if (p.fidx != 4'd15) r.fidx = p.fidx + 4'd1;
      r.ccnt       = 8'd0;
      r.last_comma = 1'b1;
    end else begin
      r.last_comma = 1'b0;
      if (p.fidx == 4'd0) begin
        for (int j = 0; j < 6; j++) begin
          if (p.ccnt >= 8'd5 || NAMES[j][8*(4 - int'(p.ccnt[2:0])) +: 8] != c) begin
            r.cand[j] = 1'b0;
          end
        end
      end else if (p.fidx < 4'd7) begin
        case (field_role(p.kind, p.fidx))
          ROLE_LATNUM:  r.lat = num_char(p.lat, c, ilim, flim);
          ROLE_LONNUM:  r.lon = num_char(p.lon, c, ilim, flim);
          ROLE_LATHEMI: if (first) r.lat_neg = (c == CH_S || c == CH_W);
          ROLE_LONHEMI: if (first) r.lon_neg = (c == CH_S || c == CH_W);
          ROLE_VALID: begin
            if (!first)            r.vcode = VAL_OTHER;
            else if (c == CH_A)    r.vcode = VAL_ACTIVE;
            else if (c == CH_ZERO) r.vcode = VAL_ZERO;
            else                   r.vcode = VAL_OTHER;
          end
          default: ;
        endcase
      end
      if (p.ccnt != 8'd255) r.ccnt = p.ccnt + 8'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/nmeapf_parse.sv]
// Per-byte line parser: line length, parse state and the star snapshot.
// Depends on nmeapf_pkg; hands a line summary to nmeapf_coord on LF.
`default_nettype none
module nmeapf_parse #(
  parameter int LINE_MAX    = 255,
  parameter int INT_DIGITS  = 5,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,   // byte taken this cycle
  input  wire logic [7:0]        byte_i,
  output nmeapf_pkg::line_t      line_o,   // summary of the stored line
  output logic                   eol_o     // LF taken this cycle
);

  localparam int LEN_W = $clog2(LINE_MAX + 1);

  logic [LEN_W-1:0]   len_q, len_d;
  logic               star_q, star_d;
  nmeapf_pkg::parse_t cur_q, cur_d;
  nmeapf_pkg::parse_t snap_q, snap_d;
  nmeapf_pkg::parse_t p;
  logic               count_ok, ok;

  assign eol_o = fire_i && (byte_i == nmeapf_pkg::CH_LF);

  always_comb begin
    len_d  = len_q;
    star_d = star_q;
    cur_d  = cur_q;
    snap_d = snap_q;
    if (eol_o) begin
      len_d  = '0;
      star_d = 1'b0;
      cur_d  = nmeapf_pkg::parse_reset();
      snap_d = nmeapf_pkg::parse_reset();
    end else if (fire_i && byte_i != nmeapf_pkg::CH_CR && len_q < LEN_W'(LINE_MAX)) begin
      len_d = len_q + LEN_W'(1);
      if (!(len_q == '0 && byte_i == nmeapf_pkg::CH_DOLLAR)) begin
        if (byte_i == nmeapf_pkg::CH_STAR) begin
          snap_d = cur_q;
          star_d = 1'b1;
        end
        cur_d = nmeapf_pkg::parse_char(cur_q, byte_i,
                                       nmeapf_pkg::ICNT_W'(INT_DIGITS),
                                       nmeapf_pkg::FCNT_W'(FRAC_DIGITS));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      star_q <= 1'b0;
      cur_q  <= nmeapf_pkg::parse_reset();
      snap_q <= nmeapf_pkg::parse_reset();
    end else begin
      len_q  <= len_d;
      star_q <= star_d;
      cur_q  <= cur_d;
      snap_q <= snap_d;
    end
  end

  // Line verdict, taken from the state before the last star if there was one.
  always_comb begin
    p        = star_q ? snap_q : cur_q;
    count_ok = (p.fidx >= 4'd7) || (p.fidx == 4'd6 && !p.last_comma);
    ok       = (len_q >= LEN_W'(6)) && count_ok && (p.kind != nmeapf_pkg::KIND_NONE);
    if (p.kind == nmeapf_pkg::KIND_GGA) ok = ok && (p.vcode != nmeapf_pkg::VAL_ZERO);
    else                                ok = ok && (p.vcode == nmeapf_pkg::VAL_ACTIVE);
    ok = ok && p.lat.nonempty && p.lon.nonempty;

    line_o.kind   = p.kind;
    line_o.status = nmeapf_pkg::STAT_REJECT;
    if (ok) begin
      if (p.lat.bad || (p.lat.icnt == '0 && p.lat.fcnt == '0) ||
          p.lon.bad || (p.lon.icnt == '0 && p.lon.fcnt == '0)) begin
        line_o.status = nmeapf_pkg::STAT_MALFORMED;
      end else begin
        line_o.status = nmeapf_pkg::STAT_FIX;
      end
    end
    line_o.lat.ival = p.lat.ival;
    line_o.lat.f6   = p.lat.f6;
    line_o.lat.neg  = p.lat_neg;
    line_o.lon.ival = p.lon.ival;
    line_o.lon.f6   = p.lon.f6;
    line_o.lon.neg  = p.lon_neg;
  end

endmodule
`default_nettype wire

[design/nmeapf_coord.sv]
// Coordinate conversion pipeline from ddmm integer and micro-minutes to
// 1e-7 degree, ending in the output register. Depends on nmeapf_pkg.
`default_nettype none
module nmeapf_coord (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire nmeapf_pkg::line_t                 line_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output nmeapf_pkg::status_e                    status_o,
  output nmeapf_pkg::kind_e                      kind_o,
  output logic signed [nmeapf_pkg::COORD_W-1:0]  lat_o,
  output logic signed [nmeapf_pkg::COORD_W-1:0]  lon_o
);

  // Reciprocals: exact floor quotients for x below 1e6 and below 1e8.
  localparam logic [20:0] RECIP100 = 21'd1342178;
  localparam logic [27:0] RECIP6   = 28'd178956971;

  typedef struct packed {
    logic [nmeapf_pkg::INT_W-1:0] ival;
    logic [nmeapf_pkg::DEG_W-1:0] deg;
    logic [nmeapf_pkg::F6_W-1:0]  f6;
    logic                         neg;
  } b_t;

  typedef struct packed {
    logic [nmeapf_pkg::MAG_W-1:0] degpart;
    logic [nmeapf_pkg::MI_W-1:0]  mi;
    logic [nmeapf_pkg::F6_W-1:0]  f6;
    logic                         neg;
  } c_t;

  typedef struct packed {
    logic [nmeapf_pkg::MAG_W-1:0] degpart;
    logic [nmeapf_pkg::MM_W-1:0]  mm;
    logic                         neg;
  } d_t;

  typedef struct packed {
    logic [nmeapf_pkg::MAG_W-1:0] degpart;
    logic [nmeapf_pkg::Q6_W-1:0]  q6;
    logic                         neg;
  } e_t;

  logic                a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic                a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, o_rdy;
  nmeapf_pkg::line_t   a_q;
  nmeapf_pkg::status_e b_st_q, c_st_q, d_st_q, e_st_q;
  nmeapf_pkg::kind_e   b_kd_q, c_kd_q, d_kd_q, e_kd_q;
  b_t                  b_lat_q, b_lon_q, b_lat_d, b_lon_d;
  c_t                  c_lat_q, c_lon_q, c_lat_d, c_lon_d;
  d_t                  d_lat_q, d_lon_q, d_lat_d, d_lon_d;
  e_t                  e_lat_q, e_lon_q, e_lat_d, e_lon_d;
  logic signed [nmeapf_pkg::COORD_W-1:0] lat_d, lon_d;

  assign o_rdy   = !valid_o || ready_i;
  assign e_rdy   = !e_v_q || o_rdy;
  assign d_rdy   = !d_v_q || e_rdy;
  assign c_rdy   = !c_v_q || d_rdy;
  assign b_rdy   = !b_v_q || c_rdy;
  assign a_rdy   = !a_v_q || b_rdy;
  assign ready_o = a_rdy;

  function automatic b_t stage_b(nmeapf_pkg::coord_t x);
    b_t          r;
    logic [40:0] prod;
    prod   = 41'(x.ival) * 41'(RECIP100);
    r.ival = x.ival;
    r.deg  = prod[27 +: nmeapf_pkg::DEG_W];
    r.f6   = x.f6;
    r.neg  = x.neg;
    return r;
  endfunction

  function automatic c_t stage_c(b_t x);
    c_t                           r;
    logic [nmeapf_pkg::INT_W-1:0] rem;
    rem       = x.ival - nmeapf_pkg::INT_W'(x.deg) * nmeapf_pkg::INT_W'(100);
    r.degpart = nmeapf_pkg::MAG_W'(x.deg) * nmeapf_pkg::MAG_W'(10000000);
    r.mi      = rem[nmeapf_pkg::MI_W-1:0];
    r.f6      = x.f6;
    r.neg     = x.neg;
    return r;
  endfunction

  function automatic d_t stage_d(c_t x);
    d_t r;
    r.degpart = x.degpart;
    r.mm      = nmeapf_pkg::MM_W'(x.mi) * nmeapf_pkg::MM_W'(1000000) +
                nmeapf_pkg::MM_W'(x.f6);
    r.neg     = x.neg;
    return r;
  endfunction

  function automatic e_t stage_e(d_t x);
    e_t          r;
    logic [55:0] prod;
    prod      = 56'(x.mm) * 56'(RECIP6);
    r.degpart = x.degpart;
    r.q6      = prod[30 +: nmeapf_pkg::Q6_W];
    r.neg     = x.neg;
    return r;
  endfunction

  function automatic logic [nmeapf_pkg::COORD_W-1:0] finish(e_t x, logic fix);
    logic [nmeapf_pkg::MAG_W-1:0] sum;
    logic [nmeapf_pkg::MAG_W-1:0] mag;
    sum = x.degpart + nmeapf_pkg::MAG_W'(x.q6);
    mag = x.neg ? (~sum + nmeapf_pkg::MAG_W'(1)) : sum;
    return fix ? mag[nmeapf_pkg::COORD_W-1:0] : '0;
  endfunction

  always_comb begin
    b_lat_d = stage_b(a_q.lat);
    b_lon_d = stage_b(a_q.lon);
    c_lat_d = stage_c(b_lat_q);
    c_lon_d = stage_c(b_lon_q);
    d_lat_d = stage_d(c_lat_q);
    d_lon_d = stage_d(c_lon_q);
    e_lat_d = stage_e(d_lat_q);
    e_lon_d = stage_e(d_lon_q);
    lat_d   = finish(e_lat_q, e_st_q == nmeapf_pkg::STAT_FIX);
    lon_d   = finish(e_lon_q, e_st_q == nmeapf_pkg::STAT_FIX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
      if (e_rdy) e_v_q <= d_v_q;
      if (o_rdy) valid_o <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) a_q <= line_i;
    if (b_rdy && a_v_q) begin
      b_st_q  <= a_q.status;
      b_kd_q  <= a_q.kind;
      b_lat_q <= b_lat_d;
      b_lon_q <= b_lon_d;
    end
    if (c_rdy && b_v_q) begin
      c_st_q  <= b_st_q;
      c_kd_q  <= b_kd_q;
      c_lat_q <= c_lat_d;
      c_lon_q <= c_lon_d;
    end
    if (d_rdy && c_v_q) begin
      d_st_q  <= c_st_q;
      d_kd_q  <= c_kd_q;
      d_lat_q <= d_lat_d;
      d_lon_q <= d_lon_d;
    end
    if (e_rdy && d_v_q) begin
      e_st_q  <= d_st_q;
      e_kd_q  <= d_kd_q;
      e_lat_q <= e_lat_d;
      e_lon_q <= e_lon_d;
    end
    if (o_rdy && e_v_q) begin
      status_o <= e_st_q;
      kind_o   <= e_kd_q;
      lat_o    <= lat_d;
      lon_o    <= lon_d;
    end
  end

endmodule
`default_nettype wire

[design/nmea_position_fix_parser.sv]
// NMEA 0183 position line parser: the top level and its checks.
// Uses nmeapf_pkg, nmeapf_parse, nmeapf_coord and the assertion macro header.
//
// Usage: received bytes enter on the s_axis channel, one per transaction,
// and every LF yields one result transaction on the m_axis channel. All
// other bytes only advance the parse state and produce nothing.
// Throughput: one byte per cycle while s_axis_tready is high; the parser
// state updates in the cycle a byte is taken, so bytes may come back to back.
// A line's result reaches m_axis through the five-stage coordinate
// pipeline (a divide by 100 and a divide by 6 done as reciprocal
// multiplies), whose first stage loads on the edge that accepts its LF,
// and then through the output register.
// Stalls: the pipeline collapses bubbles, so up to six results may be held
// while m_axis_tready is low; s_axis_tready falls only when all are full.
// Reset: the line buffer state, the star snapshot and all pipeline valid
// flags are cleared; the first byte after reset starts a new line.
// tuser carries status and sentence kind; latitude and longitude are zero
// unless status reports a valid fix.
`default_nettype none
`include "nmea_position_fix_parser_macros.svh"
module nmea_position_fix_parser #(
  parameter int LINE_MAX    = 255,
  parameter int INT_DIGITS  = 5,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [34:0] latitude, [69:35] longitude
  output logic [3:0]       m_axis_tuser    // [1:0] status, [3:2] sentence_kind
);

  logic                                   fire;
  logic                                   eol;
  nmeapf_pkg::line_t                      line;
  nmeapf_pkg::status_e                    status;
  nmeapf_pkg::kind_e                      kind;
  logic signed [nmeapf_pkg::COORD_W-1:0]  lat;
  logic signed [nmeapf_pkg::COORD_W-1:0]  lon;
  logic                                   coord_ready;

  assign fire          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = coord_ready;

  nmeapf_parse #(
    .LINE_MAX   (LINE_MAX),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .line_o (line),
    .eol_o  (eol)
  );

  nmeapf_coord u_coord (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (eol),
    .ready_o  (coord_ready),
    .line_i   (line),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .status_o (status),
    .kind_o   (kind),
    .lat_o    (lat),
    .lon_o    (lon)
  );

  assign m_axis_tdata = {2'b00, lon, lat};
  assign m_axis_tuser = {kind, status};

  `NMEAPF_ASSERT(a_zero_unless_fix, clk_i, rst_ni, m_axis_tvalid && status != nmeapf_pkg::STAT_FIX |-> lat == '0 && lon == '0)
  `NMEAPF_ASSERT(a_no_kind_rejects, clk_i, rst_ni, m_axis_tvalid && kind == nmeapf_pkg::KIND_NONE |-> status == nmeapf_pkg::STAT_REJECT)
  `NMEAPF_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `NMEAPF_ASSERT(a_hold_while_stalled, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule
`default_nettype wire

[test/nmea_position_fix_parser_tb.sv]
// Testbench for nmea_position_fix_parser: byte stream in, one line result per LF.
// Depends on nmeapf_pkg for status and kind codes; predicts results in its own model.
`timescale 1ns / 1ps
module nmea_position_fix_parser_tb;

  localparam int LINE_LIMIT = 255;
  localparam int INT_LIM    = 5;
  localparam int FRAC_LIM   = 6;

  typedef struct {
    bit [63:0] value;
    int        idig;
    int        fdig;
    bit        dot;
    bit        bad;
    bit        nonempty;
  } num_t;

  typedef struct {
    int                    fidx;
    int                    ccnt;
    bit [5:0]              cand;
    nmeapf_pkg::kind_e     kind;
    num_t                  lat;
    num_t                  lon;
    bit                    lat_neg;
    bit                    lon_neg;
    nmeapf_pkg::validity_e vcode;
    bit                    last_comma;
  } pstate_t;

  typedef struct {
    nmeapf_pkg::status_e status;
    nmeapf_pkg::kind_e   kind;
    logic [34:0]         lat;
    logic [34:0]         lon;
  } fix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  nmea_position_fix_parser dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  fix_t    expected_fixes[$];
  int      errors = 0;
  int      bytes_sent = 0;
  int      lines_seen = 0;
  bit      no_idle = 1'b0;
  int      line_len;
  bit      star_seen;
  pstate_t cur_st;
  pstate_t star_st;

  string names[6] = '{"GNGLL", "GPGLL", "GNRMC", "GPRMC", "GPGGA", "GNGGA"};

  function automatic pstate_t fresh_state();
    pstate_t p;
    p = '{default: 0, kind: nmeapf_pkg::KIND_NONE, vcode: nmeapf_pkg::VAL_EMPTY,
          lat: '{default: 0}, lon: '{default: 0}};
    p.cand = 6'h3F;
    return p;
  endfunction

  function automatic void line_clear();
    line_len  = 0;
    star_seen = 0;
    cur_st    = fresh_state();
    star_st   = fresh_state();
  endfunction

  function automatic num_t digit_push(num_t n, byte unsigned c);
    n.nonempty = 1;
    if (c >= "0" && c <= "9") begin
      if (n.dot) begin
        if (n.fdig >= FRAC_LIM) begin
          n.bad = 1;
          return n;
        end
        n.fdig++;
      end else begin
        if (n.idig >= INT_LIM) begin
          n.bad = 1;
          return n;
        end
        n.idig++;
      end
      n.value = n.value * 10 + (c - "0");
    end else if (c == "." && !n.dot) n.dot = 1;
    else n.bad = 1;
    return n;
  endfunction

  // Minutes are taken in 1e-6 units, then divided by 6 to get 1e-7 degree.
  function automatic bit [63:0] to_units(num_t n);
    bit [63:0] v, ip, m, scale;
    scale = 64'd1000000;
    v = n.value;
    for (int i = n.fdig; i < FRAC_LIM; i++) v = v * 10;
    ip = v / scale;
    m  = (ip % 100) * scale + v % scale;
    return (ip / 100) * 64'd10000000 + m / 6;
  endfunction

  function automatic int role_of(nmeapf_pkg::kind_e k, int f);
    int r;
    // 0 none, 1 lat number, 2 lat hemisphere, 3 lon number, 4 lon hemisphere, 5 validity
    r = 0;
    case (k)
      nmeapf_pkg::KIND_GLL:
        case (f) 1: r = 1; 2: r = 2; 3: r = 3; 4: r = 4; 6: r = 5; default: ; endcase
      nmeapf_pkg::KIND_RMC:
        case (f) 2: r = 5; 3: r = 1; 4: r = 2; 5: r = 3; 6: r = 4; default: ; endcase
      nmeapf_pkg::KIND_GGA:
        case (f) 2: r = 1; 3: r = 2; 4: r = 3; 5: r = 4; 6: r = 5; default: ; endcase
      default: ;
    endcase
    return r;
  endfunction

  function automatic void char_update(byte unsigned c);
    bit first;
    first = (cur_st.ccnt == 0);
    if (c == ",") begin
      if (cur_st.fidx == 0) begin
        cur_st.kind = nmeapf_pkg::KIND_NONE;
        if (cur_st.ccnt == 5) begin
          if (|cur_st.cand[1:0]) cur_st.kind = nmeapf_pkg::KIND_GLL;
          else if (|cur_st.cand[3:2]) cur_st.kind = nmeapf_pkg::KIND_RMC;
          else if (|cur_st.cand[5:4]) cur_st.kind = nmeapf_pkg::KIND_GGA;
        end
      end
      if (cur_st.fidx < 15) cur_st.fidx++;
      cur_st.ccnt = 0;
      cur_st.last_comma = 1;
      return;
    end
    cur_st.last_comma = 0;
    if (cur_st.fidx == 0) begin
      for (int j = 0; j < 6; j++)
        if (cur_st.ccnt >= 5 || names[j][cur_st.ccnt] != c) cur_st.cand[j] = 1'b0;
    end else if (cur_st.fidx < 7) begin
      case (role_of(cur_st.kind, cur_st.fidx))
        1: cur_st.lat = digit_push(cur_st.lat, c);
        2: if (first) cur_st.lat_neg = (c == "S" || c == "W");
        3: cur_st.lon = digit_push(cur_st.lon, c);
        4: if (first) cur_st.lon_neg = (c == "S" || c == "W");
        5: begin
          if (!first)        cur_st.vcode = nmeapf_pkg::VAL_OTHER;
          else if (c == "A") cur_st.vcode = nmeapf_pkg::VAL_ACTIVE;
          else if (c == "0") cur_st.vcode = nmeapf_pkg::VAL_ZERO;
          else               cur_st.vcode = nmeapf_pkg::VAL_OTHER;
        end
        default: ;
      endcase
    end
    if (cur_st.ccnt < 255) cur_st.ccnt++;
  endfunction

  function automatic fix_t line_verdict();
    pstate_t p;
    fix_t    f;
    bit      ok;
    bit [63:0] a, b;
    p = star_seen ? star_st : cur_st;
    f.status = nmeapf_pkg::STAT_REJECT;
    f.kind   = p.kind;
    f.lat    = '0;
    f.lon    = '0;
    ok = line_len >= 6 && (p.fidx >= 7 || (p.fidx == 6 && !p.last_comma)) &&
         p.kind != nmeapf_pkg::KIND_NONE;
    if (ok) ok = (p.kind == nmeapf_pkg::KIND_GGA) ? p.vcode != nmeapf_pkg::VAL_ZERO :
                                                    p.vcode == nmeapf_pkg::VAL_ACTIVE;
    ok = ok && p.lat.nonempty && p.lon.nonempty;
    if (ok) begin
      if (p.lat.bad || p.lat.idig + p.lat.fdig == 0 ||
          p.lon.bad || p.lon.idig + p.lon.fdig == 0) begin
        f.status = nmeapf_pkg::STAT_MALFORMED;
      end else begin
        a = to_units(p.lat);
        b = to_units(p.lon);
        f.status = nmeapf_pkg::STAT_FIX;
        f.lat = p.lat_neg ? 35'(64'd0 - a) : a[34:0];
        f.lon = p.lon_neg ? 35'(64'd0 - b) : b[34:0];
      end
    end
    return f;
  endfunction

  function automatic void byte_predict(byte unsigned c);
    fix_t f;
    if (c == nmeapf_pkg::CH_LF) begin
      f = line_verdict();
      expected_fixes = {expected_fixes, f};
      line_clear();
      return;
    end
    if (c == nmeapf_pkg::CH_CR || line_len >= LINE_LIMIT) return;
    if (line_len == 0 && c == "$") begin
      line_len++;
      return;
    end
    line_len++;
    if (c == "*") begin
      star_st   = cur_st;
      star_seen = 1;
    end
    char_update(c);
  endfunction

  // Leaves tvalid high on return; the next call or the caller drops it.
  task automatic send_byte(byte unsigned c);
    while (!no_idle && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    byte_predict(c);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    fix_t exp_f;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      lines_seen++;
      if (expected_fixes.size() == 0) begin
        $display("%0t: result with no line pending: tuser %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        exp_f = expected_fixes.pop_front();
        if (m_axis_tuser[1:0] !== exp_f.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_f.status,
                   m_axis_tuser[1:0]);
          errors++;
        end
        if (m_axis_tuser[3:2] !== exp_f.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_f.kind,
                   m_axis_tuser[3:2]);
          errors++;
        end
        if (m_axis_tdata[34:0] !== exp_f.lat) begin
          $display("%0t: latitude expected %h actual %h", $time, exp_f.lat,
                   m_axis_tdata[34:0]);
          errors++;
        end
        if (m_axis_tdata[69:35] !== exp_f.lon) begin
          $display("%0t: longitude expected %h actual %h", $time, exp_f.lon,
                   m_axis_tdata[69:35]);
          errors++;
        end
      end
    end
  end

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
    return s;
  endfunction

  // Coordinate number, mostly well formed, sometimes empty, too long or with junk.
  function automatic string rand_number();
    string s;
    int    k;
    k = $urandom_range(19);
    if (k == 0) return "";
    s = digits($urandom_range(1, 5));
    if ($urandom_range(3) != 0) s = {s, ".", digits($urandom_range(0, 6))};
    if (k == 1) s = {s, digits(2)};
    if (k == 2) s = {"-", s};
    if (k == 3) s = {s, ".1"};
    if (k == 4) s = ".";
    return s;
  endfunction

  function automatic string rand_hemi(bit lat);
    int k;
    k = $urandom_range(9);
    if (k == 0) return "";
    if (k == 1) return "SX";
    if (lat) begin
      if ($urandom_range(1)) return "N";
      return "S";
    end
    if ($urandom_range(1)) return "E";
    return "W";
  endfunction

  function automatic string rand_sentence();
    string nm, la, lo, lah, loh, v, q, s;
    int    k;
    nm  = names[$urandom_range(5)];
    if ($urandom_range(15) == 0) nm = "GPXYZ";
    la  = rand_number();
    lo  = rand_number();
    lah = rand_hemi(1);
    loh = rand_hemi(0);
    k = $urandom_range(9);
    if (k < 7)       v = "A";
    else if (k == 7) v = "V";
    else if (k == 8) v = "0";
    else             v = "";
    q = v;
    if (v == "A") q = "1";
    if (nm[2] == "G" && nm[3] == "L")
      s = {nm, ",", la, ",", lah, ",", lo, ",", loh, ",123519,", v};
    else if (nm[2] == "R")
      s = {nm, ",123519,", v, ",", la, ",", lah, ",", lo, ",", loh, ",x"};
    else
      s = {nm, ",123519,", la, ",", lah, ",", lo, ",", loh, ",", q, ",08"};
    if ($urandom_range(1)) s = {"$", s};
    if ($urandom_range(2) != 0) s = {s, "*", digits(2)};
    if ($urandom_range(7) == 0) s = {s, ","};
    if ($urandom_range(1)) s = {s, "\r"};
    return s;
  endfunction

  task automatic test_directed();
    send_text("$GPGLL,4916.45,N,12311.12,W,225444,A*1D\r\n");
    send_text("$GNGLL,9000.000000,S,18059.999999,E,0,A\n");
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4\n");
    send_text("$GNRMC,123519,V,4807.038,N,01131.000,E,x\n");
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08\n");
    send_text("$GNGGA,1,4807.038,N,01131.000,E,0,08\n");
    send_text("$GPGGA,1,99999.999999,S,00000,W,,08\n");
    send_text("$GPGGA,1,123456,N,1.2.3,E,1,08\n");
    send_text("$GPGGA,1,12.3456789,N,-1,E,1,08\n");
    send_text("$GPGGA,1,,N,0100,E,1,08\n");
    send_text("$GPGLL,1,N,2,E,3,A,\n");
    send_text("$GPGLL,1,N,2,E,3\n");
    send_text("$GP\n");
    send_text("\n");
    send_text("$GPGGA,1,12.5,N,7,E,1,*ab,12.5,N\n");
    send_text("GPGGA,1,.,N,7,E,1*x*y\n");
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80); send_byte(8'h7F);
    send_text("\n");
  endtask

  task automatic test_overlong_line();
    send_text("$GPGGA,1,1,N,2,E,1,");
    for (int i = 0; i < 250; i++) send_byte($urandom_range(1) ? "," : "9");
    send_text("\n");
  endtask

  task automatic test_random_lines();
    string s;
    int    n;
    n = 0;
    while (n < 350) begin
      no_idle = (n >= 100 && n < 250);
      if ($urandom_range(9) == 0) begin
        for (int i = $urandom_range(1, 12); i > 0; i--) begin
          send_byte(8'($urandom_range(255)));
          n++;
        end
      end else begin
        s = rand_sentence();
        send_text(s);
        n += s.len();
      end
      send_byte(nmeapf_pkg::CH_LF);
      n++;
    end
    no_idle = 0;
  endtask

  initial begin
    line_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overlong_line();
    test_random_lines();
    s_axis_tvalid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes and checked %0d line results (directed, overlong, random).",
             bytes_sent, lines_seen);
    if (errors == 0 && expected_fixes.size() == 0) begin
      $display("** nmea_position_fix_parser: PASSED **");
    end else begin
      $display("** nmea_position_fix_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out.");
    $display("** nmea_position_fix_parser: FAILED **");
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/nmeapf_pkg.sv
design/nmeapf_parse.sv
design/nmeapf_coord.sv
design/nmea_position_fix_parser.sv
test/nmea_position_fix_parser_tb.sv
